[sv/sha256_byte_stream_hasher_top_defines.svh]
// Assertion macros shared by the SHA-256 hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
// Checked only while reset is released.
`define SHA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, during reset too.
`define SHA_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

[sv/sha_pkg.sv]
// Package with types, constants and round functions of the SHA-256 hasher.
`default_nettype none
package sha_pkg;
    localparam int BUF_WORDS = 16;
    localparam int CNT_W = 61;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FIN, S_PAD80, S_ZERO, S_LEN, S_OUT
    } t_state;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction
endpackage
`default_nettype wire

[sv/sha_ifs.sv]
// Handshake interfaces for the byte input and the digest output.
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[sv/sha256_byte_stream_hasher_top.sv]
// Top level of the SHA-256 byte stream hasher.
//   Channel  Direction  Carries
//   i_in     in         data_byte, byte_valid, last_byte
//   o_out    out        digest_word, word_index, last_word
// A byte is taken while idle; the 64th byte of a block starts a compression
// (load the block from the buffer RAM, 64 rounds, 1 add). A last item
// pads byte by byte, plus one or two compressions, then holds each digest word
// until taken. No item is taken while busy.
// Reset is synchronous, active low, and restores the initial hash values.
`default_nettype none
`include "sha256_byte_stream_hasher_top_defines.svh"
module sha256_byte_stream_hasher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    import sha_pkg::*;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [5:0]         r_pos, n_pos;
    logic [6:0]         r_cnt, n_cnt;
    logic [2:0]         r_idx, n_idx;
    logic [23:0]        r_acc, n_acc;
    logic [31:0]        r_h [8];
    logic [31:0]        n_h [8];
    logic [31:0]        r_v [8];
    logic [31:0]        n_v [8];
    logic [31:0]        r_w [16];
    logic [31:0]        n_w [16];

    logic               push;
    logic [7:0]         push_byte;
    logic               ram_we;
    logic [3:0]         ram_raddr;
    logic [31:0]        ram_rdata;
    logic               in_acc;
    logic [63:0]        bit_len;
    logic [31:0]        t1, t2, w_next;

    sha_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_pos[5:2]),
        .i_wdata({r_acc, push_byte}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Outputs and handshake.
    always_comb begin
        i_in.ready        = (r_state == S_IDLE);
        o_out.valid       = (r_state == S_OUT);
        o_out.digest_word = r_h[r_idx];
        o_out.word_index  = r_idx;
        o_out.last_word   = (r_idx == 3'd7);
        ram_raddr         = r_cnt[3:0];
    end

    assign in_acc  = i_in.valid && i_in.ready;
    assign bit_len = {r_count, 3'b000};
    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K[r_cnt[5:0]] + r_w[0];
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next = r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);

    // Byte written into the block this cycle, from the input or the padder.
    always_comb begin
        push      = 1'b0;
        push_byte = 8'h00;
        unique case (r_state)
            S_IDLE: begin
                push      = in_acc && i_in.byte_valid;
                push_byte = i_in.data_byte;
            end
            S_PAD80: begin
                push      = 1'b1;
                push_byte = 8'h80;
            end
            S_ZERO: begin
                push = (r_pos != 6'd56);
            end
            S_LEN: begin
                push      = 1'b1;
                push_byte = bit_len[6'd63 - {r_pos[2:0], 3'b000} -: 8];
            end
            default: begin
                push = 1'b0;
            end
        endcase
        ram_we = push && (r_pos[1:0] == 2'd3);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_count = r_count;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_h     = r_h;
        n_v     = r_v;
        n_w     = r_w;
        if (push) begin
            n_pos = r_pos + 6'd1;
            n_acc = {r_acc[15:0], push_byte};
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_valid) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.byte_valid && r_pos == 6'd63) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                        n_ret   = i_in.last_byte ? S_PAD80 : S_IDLE;
                    end else if (i_in.last_byte) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                if (r_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                    n_ret   = S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_pos == 6'd56) begin
                    n_state = S_LEN;
                end else if (r_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                    n_ret   = S_ZERO;
                end
            end
            S_LEN: begin
                if (r_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                    n_ret   = S_OUT;
                end
            end
            S_LOAD: begin
                // Read data arrives in the cycle after its address.
                if (r_cnt != 7'd0) begin
                    for (int j = 0; j < 15; j++) begin
                        n_w[j] = r_w[j + 1];
                    end
                    n_w[15] = ram_rdata;
                end
                if (r_cnt == 7'd16) begin
                    n_state = S_ROUND;
                    n_cnt   = '0;
                    n_v     = r_h;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ROUND: begin
                for (int j = 0; j < 15; j++) begin
                    n_w[j] = r_w[j + 1];
                end
                n_w[15] = w_next;
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                for (int j = 0; j < 8; j++) begin
                    n_h[j] = r_h[j] + r_v[j];
                end
                n_state = r_ret;
                n_idx   = '0;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                        n_h     = IV;
                        n_count = '0;
                        n_pos   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_h     <= IV;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_h     <= n_h;
        end
        r_acc <= n_acc;
        r_v   <= n_v;
        r_w   <= n_w;
    end

    `SHA_CHECK(a_one_side, o_out.valid |-> !i_in.ready, "input taken while digest pending")
    `SHA_CHECK(a_digest_done, (o_out.valid && o_out.ready && o_out.last_word) |=> (r_pos == 6'd0 && r_count == '0), "state not cleared after digest")
    `SHA_CHECK(a_fill_block, (in_acc && i_in.byte_valid && r_pos == 6'd63) |=> (r_state == S_LOAD), "full block not compressed")
    `SHA_CHECK_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE), "reset did not return to idle")
endmodule
`default_nettype wire

[sv/sha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
